@@ hw/rtl/shb_pkg.sv @@
// Shared types, constants and the round-constant table of the SHA-256 byte-stream hasher.
// Used by shb_core and sha256_byte_stream_hasher_top; depends on nothing else.
`timescale 1ns / 1ps

package shb_pkg;

    localparam int unsigned BLOCK_BYTES     = 64;
    localparam int unsigned LEN_FIELD_START = 56;
    localparam logic [7:0]  PAD_MARK        = 8'h80;
    localparam int unsigned HASH_WORDS      = 8;

    typedef logic [HASH_WORDS-1:0][31:0] t_hash;

    localparam t_hash INITIAL_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Commands from the sequencer to the compression core.
    typedef struct packed {
        logic       shift;      // shift one byte into the block window
        logic [7:0] data_byte;
        logic       start;      // begin 64 rounds on the window
        logic       init;       // reload the initial hash values
    } t_core_ctrl;

    typedef struct packed {
        logic busy;
    } t_core_stat;

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/shb_core.sv @@
// SHA-256 compression core: 16-word block window, one round per cycle, hash state.
// Depends on shb_pkg.
`timescale 1ns / 1ps

module shb_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shb_pkg::t_core_ctrl i_ctrl,
    output shb_pkg::t_core_stat o_stat,
    output shb_pkg::t_hash      o_hash
);
    import shb_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_cstate;

    t_cstate             r_state;
    logic [5:0]          r_round;
    t_hash               r_h;
    t_hash               r_v;      // working variables, index 0 is a
    logic [15:0][31:0]   r_w;      // index 15 holds the oldest schedule word
    logic [511:0]        w_flat;
    t_hash               n_v;
    logic [31:0]         n_wnew;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    assign w_flat = r_w;

    always_comb begin
        logic [31:0] e, a, big1, big0, choose, major, t1, t2, x, y, s0, s1;
        e      = r_v[4];
        a      = r_v[0];
        big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        choose = (e & r_v[5]) ^ (~e & r_v[6]);
        t1     = r_v[7] + big1 + choose + round_const(r_round) + r_w[15];
        big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        major  = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + major;
        n_v    = {r_v[6:4], r_v[3] + t1, r_v[2:0], t1 + t2};

        x      = r_w[14];
        y      = r_w[1];
        s0     = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1     = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        n_wnew = s1 + r_w[6] + s0 + r_w[15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_h     <= INITIAL_HASH;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    // A byte may be shifted in at the same edge that starts the rounds.
                    if (i_ctrl.shift) begin
                        r_w <= {w_flat[503:0], i_ctrl.data_byte};
                    end
                    if (i_ctrl.start) begin
                        r_v     <= r_h;
                        r_round <= '0;
                        r_state <= C_ROUND;
                    end
                    if (i_ctrl.init) begin
                        r_h <= INITIAL_HASH;
                    end
                end
                C_ROUND: begin
                    r_v     <= n_v;
                    r_w     <= {r_w[14:0], n_wnew};
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    for (int i = 0; i < HASH_WORDS; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != C_IDLE);
    assign o_hash      = r_h;

endmodule

@@ hw/rtl/sha256_byte_stream_hasher_top.sv @@
// Top level of the SHA-256 byte-stream hasher: handshakes, padding sequencer, digest output.
// Depends on shb_pkg and shb_core.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_ready  | i_item: data_byte, byte_present, end_of_message
//  output  | out       | o_valid / i_ready  | o_item: digest_word, word_index, last_word
//
// A byte word is shifted in as it is taken; the byte that completes a 64-byte block
// also starts the 64 rounds of the round unit, the hash update and the hand-back.
// An end word then shifts in pad bytes, one per cycle, up to the end of the block (and a
// whole extra block when the length field spills), compresses each block, and offers
// eight digest words.
// Synchronous active-low reset restores the initial hash values and clears all counts.
// The output stalls freely on i_ready; no input is taken until the eighth word leaves.

module sha256_byte_stream_hasher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  shb_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output shb_pkg::t_out_item o_item
);
    import shb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_OUT
    } t_state;

    t_state      r_state, n_state;
    t_state      r_after, n_after;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic        r_final, n_final;
    logic        r_pad_first, n_pad_first;
    logic [2:0]  r_idx, n_idx;

    t_core_ctrl  w_ctrl;
    t_core_stat  w_stat;
    t_hash       w_hash;
    logic [63:0] w_bits;
    logic [7:0]  w_pad_byte;
    logic        w_final_now;

    shb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .o_hash  (w_hash)
    );

    assign w_bits = {r_count, 3'b000};

    // The length field fills positions 56..63 of the final block, big-endian.
    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = PAD_MARK;
        end else if (r_final && (r_fill >= 6'(LEN_FIELD_START))) begin
            w_pad_byte = w_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    assign w_final_now = r_pad_first ? (r_fill < 6'(LEN_FIELD_START)) : r_final;

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_fill      = r_fill;
        n_count     = r_count;
        n_final     = r_final;
        n_pad_first = r_pad_first;
        n_idx       = r_idx;
        w_ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.byte_present) begin
                        w_ctrl.shift     = 1'b1;
                        w_ctrl.data_byte = i_item.data_byte;
                        n_count          = r_count + 61'd1;
                        n_fill           = r_fill + 6'd1;
                    end
                    if (i_item.byte_present && (r_fill == 6'd63)) begin
                        w_ctrl.start = 1'b1;
                        n_state      = S_COMP;
                        n_after      = i_item.end_of_message ? S_PAD : S_IDLE;
                        n_pad_first  = 1'b1;
                    end else if (i_item.end_of_message) begin
                        n_state     = S_PAD;
                        n_pad_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                w_ctrl.shift     = 1'b1;
                w_ctrl.data_byte = w_pad_byte;
                n_pad_first      = 1'b0;
                n_final          = w_final_now;
                n_fill           = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    // A spilled block is followed by one more block that carries the length.
                    w_ctrl.start = 1'b1;
                    n_state      = S_COMP;
                    n_after      = w_final_now ? S_OUT : S_PAD;
                    n_final      = 1'b1;
                end
            end
            S_COMP: begin
                if (!w_stat.busy) begin
                    n_state = r_after;
                    n_idx   = '0;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        w_ctrl.init = 1'b1;
                        n_state     = S_IDLE;
                        n_fill      = '0;
                        n_count     = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_final     <= 1'b0;
            r_pad_first <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_final     <= n_final;
            r_pad_first <= n_pad_first;
            r_idx       <= n_idx;
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_item.digest_word = w_hash[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = (r_idx == 3'd7);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while digest words are pending");

    a_core_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.busy)
        else $error("ready while the round unit is still busy");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_item.last_word) |=>
            (o_valid && (o_item.word_index == 3'($past(o_item.word_index) + 3'd1))))
        else $error("digest words out of order");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_item.last_word) |=> (o_ready && (r_fill == 6'd0)))
        else $error("block not ready for a new message after the last word");

endmodule
